// ----- hw/rtl/bse_pkg.sv -----
package bse_pkg;

    localparam int FUNC_W     = 3;
    localparam int ELEM_W     = 10;
    localparam int CAP_W      = 11;
    localparam int POP_W      = 11;
    // Word and bit position of an element; sized for the narrowest legal word (8 bits)
    // and the widest (64 bits) over the full element range.
    localparam int WORD_IDX_W = 7;
    localparam int BIT_IDX_W  = 6;
    localparam int BASE_W     = 12;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_ERASE  = 3'd1,
        FN_FIND   = 3'd2,
        FN_FIRST  = 3'd3,
        FN_COUNT  = 3'd4,
        FN_EMPTY  = 3'd5
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic                  range_error;
        logic [WORD_IDX_W-1:0] word;
        logic [BIT_IDX_W-1:0]  bit_idx;
    } cmd_t;

    typedef struct packed {
        logic              range_error;
        logic              member;
        logic              first_found;
        logic [ELEM_W-1:0] first_index;
        logic [POP_W-1:0]  population;
        logic              is_empty;
    } rsp_t;

endpackage

// ----- hw/rtl/bse_if.sv -----
interface bse_req_if;
    logic                      valid;
    logic                      ready;
    logic [bse_pkg::FUNC_W-1:0] func;
    logic [bse_pkg::ELEM_W-1:0] element;

    modport source (output valid, output func, output element, input ready);
    modport sink   (input valid, input func, input element, output ready);
endinterface

interface bse_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       range_error;
    logic                       member;
    logic                       first_found;
    logic [bse_pkg::ELEM_W-1:0] first_index;
    logic [bse_pkg::POP_W-1:0]  population;
    logic                       is_empty;

    modport source (output valid, output range_error, output member, output first_found,
                    output first_index, output population, output is_empty, input ready);
    modport sink   (input valid, input range_error, input member, input first_found,
                    input first_index, input population, input is_empty, output ready);
endinterface

// ----- hw/rtl/bse_front.sv -----
module bse_front #(
    parameter int WORD_BITS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bse_req_if.sink                   req,
    input  logic [bse_pkg::CAP_W-1:0] cap_eff,
    output logic                      push_valid,
    input  logic                      push_ready,
    output bse_pkg::cmd_t             push_cmd
);
    import bse_pkg::*;

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W      = 28;

    typedef struct packed {
        func_t                 func;
        logic                  range_error;
        logic [WORD_IDX_W-1:0] word;
        logic [ELEM_W-1:0]     element;
    } hold_t;

    logic        hold_valid_reg, hold_valid_next;
    hold_t       hold_reg, hold_next;
    logic [PROD_W-1:0] prod;
    logic [BASE_W-1:0] word_base;
    func_t       in_func;
    logic        elem_op;

    assign req.ready  = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;

    // Word number by reciprocal multiply; exact over the element range.
    assign prod    = PROD_W'(req.element) * PROD_W'(RECIP);
    assign in_func = func_t'(req.func);
    assign elem_op = (in_func == FN_INSERT) || (in_func == FN_ERASE)
                  || (in_func == FN_FIND) || (in_func == FN_FIRST);

    assign word_base = BASE_W'(hold_reg.word) * BASE_W'(WORD_BITS);

    always_comb
    begin
        push_cmd.func        = hold_reg.func;
        push_cmd.range_error = hold_reg.range_error;
        push_cmd.word        = hold_reg.word;
        push_cmd.bit_idx     = BIT_IDX_W'(hold_reg.element - word_base[ELEM_W-1:0]);
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (req.valid && req.ready)
        begin
            hold_valid_next       = 1'b1;
            hold_next.func        = in_func;
            hold_next.element     = req.element;
            hold_next.word        = prod[RECIP_SHIFT +: WORD_IDX_W];
            hold_next.range_error = elem_op && ({1'b0, req.element} >= cap_eff);
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ----- hw/rtl/bse_queue.sv -----
module bse_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bse_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bse_pkg::cmd_t pop_cmd
);
    import bse_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/bse_back.sv -----
module bse_back #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int WORD_BITS    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bse_pkg::CAP_W-1:0] cap_eff,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  bse_pkg::cmd_t             pop_cmd,
    bse_rsp_if.source                 rsp
);
    import bse_pkg::*;

    localparam int WORDS_TOTAL = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORDS_ELEM  = ((1 << ELEM_W) + WORD_BITS - 1) / WORD_BITS;
    localparam int MEM_DEPTH   = (WORDS_TOTAL < WORDS_ELEM) ? WORDS_TOTAL : WORDS_ELEM;
    localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int BI_W        = $clog2(WORD_BITS);
    localparam int CNT_W       = $clog2(WORD_BITS + 1);
    localparam int NCHUNK      = (WORD_BITS + 7) / 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                first_reg, first_next;
    logic [POP_W-1:0]    acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;

    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] word_valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_hit_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [WORD_BITS-1:0] data, cap_mask, start_mask, masked;
    logic [BASE_W-1:0]    cap_ext, room;
    logic                 last;
    logic [BI_W-1:0]      low_pos;
    logic [CNT_W-1:0]     word_pop;
    logic [POP_W-1:0]     acc_sum;
    logic [AW-1:0]        scan_addr;

    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [CNT_W-1:0] total;
        logic [3:0]       chunk;
        total = '0;
        for (int c = 0; c < NCHUNK; c++)
        begin
            chunk = '0;
            for (int j = 0; j < 8; j++)
            begin
                if (c * 8 + j < WORD_BITS)
                begin
                    chunk = chunk + 4'(v[c * 8 + j]);
                end
            end
            total = total + CNT_W'(chunk);
        end
        return total;
    endfunction

    // Word memory with registered read; a word never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= word_valid_reg[rd_addr];
        end
    end

    assign data    = rd_hit_reg ? rd_data_reg : '0;
    assign cap_ext = BASE_W'(cap_eff);
    assign room    = (cap_ext > base_reg) ? (cap_ext - base_reg) : '0;
    assign last    = (cur_reg == AW'(MEM_DEPTH - 1))
                  || (base_reg + BASE_W'(WORD_BITS) >= cap_ext);
    assign scan_addr = last ? cur_reg : cur_reg + AW'(1);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cap_mask[i]   = (BASE_W'(i) < room);
            start_mask[i] = !first_reg || (BI_W'(i) >= cmd_reg.bit_idx[BI_W-1:0]);
        end
    end

    assign masked = data & cap_mask & start_mask;

    always_comb
    begin
        low_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                low_pos = BI_W'(i);
            end
        end
    end

    assign word_pop  = popcount(masked);
    assign acc_sum   = acc_reg + POP_W'(word_pop);
    assign pop_ready = (state_reg == S_IDLE) && !out_valid_reg;

    assign rsp.valid       = out_valid_reg;
    assign rsp.range_error = out_reg.range_error;
    assign rsp.member      = out_reg.member;
    assign rsp.first_found = out_reg.first_found;
    assign rsp.first_index = out_reg.first_index;
    assign rsp.population  = out_reg.population;
    assign rsp.is_empty    = out_reg.is_empty;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        base_next      = base_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = cmd_reg.word[AW-1:0];
        wr_data        = data;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = ((pop_cmd.func == FN_COUNT) || (pop_cmd.func == FN_EMPTY))
                        ? '0 : pop_cmd.word[AW-1:0];
                if (pop_valid && pop_ready)
                begin
                    cmd_next = pop_cmd;
                    out_next = '0;
                    unique case (pop_cmd.func)
                        FN_INSERT, FN_ERASE, FN_FIND, FN_FIRST:
                        begin
                            if (pop_cmd.range_error)
                            begin
                                out_next.range_error = 1'b1;
                                out_valid_next       = 1'b1;
                            end
                            else if (pop_cmd.func == FN_FIRST)
                            begin
                                cur_next   = pop_cmd.word[AW-1:0];
                                base_next  = BASE_W'(pop_cmd.word) * BASE_W'(WORD_BITS);
                                first_next = 1'b1;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        FN_COUNT, FN_EMPTY:
                        begin
                            cur_next   = '0;
                            base_next  = '0;
                            first_next = 1'b0;
                            acc_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // Read-modify-write of one word, or a single bit test.
                if (cmd_reg.func == FN_FIND)
                begin
                    out_next.member = data[cmd_reg.bit_idx[BI_W-1:0]];
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_data[cmd_reg.bit_idx[BI_W-1:0]] = (cmd_reg.func == FN_INSERT);
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                rd_addr    = scan_addr;
                cur_next   = scan_addr;
                base_next  = base_reg + BASE_W'(WORD_BITS);
                first_next = 1'b0;
                priority if (cmd_reg.func == FN_FIRST)
                begin
                    if (masked != '0)
                    begin
                        out_next.first_found = 1'b1;
                        out_next.first_index = ELEM_W'(base_reg + BASE_W'(low_pos));
                        out_valid_next       = 1'b1;
                        state_next           = S_IDLE;
                    end
                    else if (last)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (cmd_reg.func == FN_COUNT)
                begin
                    acc_next = acc_sum;
                    if (last)
                    begin
                        out_next.population = acc_sum;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else
                begin
                    if ((masked != '0) || last)
                    begin
                        out_next.is_empty = (masked == '0);
                        out_valid_next    = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            cur_reg       <= '0;
            base_reg      <= '0;
            first_reg     <= 1'b0;
            acc_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            cur_reg       <= cur_next;
            base_reg      <= base_next;
            first_reg     <= first_next;
            acc_reg       <= acc_next;
            out_reg       <= out_next;
        end
    end

endmodule

// ----- hw/rtl/bitmap_set_engine.sv -----
// Bitmap set engine: holds a set of element numbers as a bitmap in a word memory,
// empty after reset. Each request transaction carries an operation (insert, erase,
// find, find first, count, empty test) and an element number, and yields exactly one
// response transaction. Elements at or beyond the capacity register (limited to
// MAX_ELEMENTS) get range_error on the four element operations; members above a lowered
// capacity stay stored but hidden. Timing: a front stage decodes the request into word
// and bit position and checks range, then a two-entry queue feeds the execution stage.
// Insert, erase and find pass through the execution stage as a memory read, then a
// write or test. Find first, count and empty test walk the memory one word per cycle,
// visiting at least one word and up to ceil(effective capacity / WORD_BITS) words
// (16 with the defaults); find first starts at the element's word and empty test
// stops at the first member. Requests keep flowing into the queue while a response
// waits, until the queue fills. Write capacity only while idle.
module bitmap_set_engine #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int WORD_BITS    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bse_req_if.sink                   req,
    bse_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [bse_pkg::CAP_W-1:0] cfg_wr_data
);
    import bse_pkg::*;

    // Capacity values above this limit act as the limit.
    localparam int CAP_MAX = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] cap_eff;
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic             pop_valid, pop_ready;
    cmd_t             pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    assign cap_eff = (capacity_reg > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : capacity_reg;

    // Decode and range-check incoming requests.
    bse_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cap_eff    (cap_eff),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decouple the front from the memory walk.
    bse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute against the word memory and hold the response.
    bse_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .WORD_BITS    (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_eff   (cap_eff),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

// ----- hw/rtl/bse_checker.sv -----
module bse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       range_error,
    input logic                       member,
    input logic                       first_found,
    input logic [bse_pkg::ELEM_W-1:0] first_index,
    input logic [bse_pkg::POP_W-1:0]  population,
    input logic                       is_empty
);
    import bse_pkg::*;

    // Hold a stalled response unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_index)
            && $stable(population) && $stable({range_error, member, first_found, is_empty}))
        else $error("response changed while stalled");

    // One operation answers per response.
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({range_error, member, first_found,
            (population != '0), is_empty}) <= 1)
        else $error("response carries answers of more than one operation");

    a_index_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !first_found |-> first_index == '0)
        else $error("first_index set without first_found");

    a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> population <= POP_W'(1024))
        else $error("population beyond element range");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .range_error (rsp.range_error),
    .member      (rsp.member),
    .first_found (rsp.first_found),
    .first_index (rsp.first_index),
    .population  (rsp.population),
    .is_empty    (rsp.is_empty)
);

// ----- verif/bitmap_set_engine_test.sv -----
module bitmap_set_engine_test;
    import bse_pkg::*;

    // Kinds of row in the directed table: a request, or a capacity write.
    localparam logic ROW_REQUEST = 1'b0;
    localparam logic ROW_CAP     = 1'b1;

    // Function codes with no operation behind them.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    // Idle time after the last response before a capacity write. A scan can
    // visit 16 words, so leave comfortable margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int ELEM_SPAN     = 1024;

    typedef struct {
        logic              kind;
        logic [FUNC_W-1:0] func;
        logic [ELEM_W-1:0] element;
        logic [CAP_W-1:0]  cap;
        logic              typed;
        rsp_t              answer;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    bse_req_if req ();
    bse_rsp_if rsp ();

    bitmap_set_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req.sink),
        .rsp        (rsp.source),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow copy of the set and of the capacity register.
    bit [ELEM_SPAN-1:0] shadow_set;
    logic [CAP_W-1:0]   shadow_cap;

    rsp_t pending_rsp[$];
    dir_row_t dir_rows[$];

    int error_count;
    int sent_count;
    int checked_count;
    int stall_pct;
    int burst_left;
    int max_gap;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Compute the response of one request and apply its effect on the set.
    function automatic rsp_t apply_request(logic [FUNC_W-1:0] fn, logic [ELEM_W-1:0] el);
        rsp_t r;
        int   lim;
        logic bad;
        r = '0;
        lim = (shadow_cap > ELEM_SPAN) ? ELEM_SPAN : int'(shadow_cap);
        bad = (int'(el) >= lim);
        case (fn)
            FN_INSERT, FN_ERASE:
            begin
                r.range_error = bad;
                if (!bad)
                    shadow_set[el] = (fn == FN_INSERT);
            end
            FN_FIND:
            begin
                r.range_error = bad;
                if (!bad)
                    r.member = shadow_set[el];
            end
            FN_FIRST:
            begin
                r.range_error = bad;
                if (!bad)
                begin
                    for (int e = el; e < lim; e++)
                    begin
                        if (shadow_set[e])
                        begin
                            r.first_found = 1'b1;
                            r.first_index = e[ELEM_W-1:0];
                            break;
                        end
                    end
                end
            end
            FN_COUNT:
            begin
                for (int e = 0; e < lim; e++)
                    r.population += POP_W'(shadow_set[e]);
            end
            FN_EMPTY:
            begin
                r.is_empty = 1'b1;
                for (int e = 0; e < lim; e++)
                    if (shadow_set[e])
                        r.is_empty = 1'b0;
            end
            default: ;  // unused codes: no effect, all-zero response
        endcase
        return r;
    endfunction

    // Print one line per mismatching field and count it.
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (response %0d)",
                 what, got, want, checked_count);
        error_count++;
    endtask

    // Response side: stall ready on its own pattern, check every transaction
    // against the oldest pending expectation, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("MISMATCH unexpected response transaction");
                    error_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.range_error !== want.range_error)
                        report_mismatch("range_error", rsp.range_error, want.range_error);
                    if (rsp.member !== want.member)
                        report_mismatch("member", rsp.member, want.member);
                    if (rsp.first_found !== want.first_found)
                        report_mismatch("first_found", rsp.first_found, want.first_found);
                    if (rsp.first_index !== want.first_index)
                        report_mismatch("first_index", rsp.first_index, want.first_index);
                    if (rsp.population !== want.population)
                        report_mismatch("population", rsp.population, want.population);
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", rsp.is_empty, want.is_empty);
                end
                checked_count++;
            end
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Present one request and hold it until accepted. Valid stays high
    // across a burst; between bursts drop it for a random gap.
    task automatic send_request(logic [FUNC_W-1:0] fn, logic [ELEM_W-1:0] el,
                                logic typed, rsp_t answer);
        rsp_t predicted;
        int   gap;
        req.valid   <= 1'b1;
        req.func    <= fn;
        req.element <= el;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = apply_request(fn, el);
        pending_rsp.push_back(typed ? answer : predicted);
        sent_count++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(12);
            gap = $urandom_range(max_gap);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait for the engine to drain, then write the capacity register.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_cap = value;
    endtask

    function automatic rsp_t answer_of(int rerr, int pop, int empty);
        rsp_t r;
        r = '0;
        r.range_error = rerr[0];
        r.population  = POP_W'(pop);
        r.is_empty    = empty[0];
        return r;
    endfunction

    function automatic dir_row_t req_row(logic [FUNC_W-1:0] fn, logic [ELEM_W-1:0] el,
                                         logic typed = 1'b0, rsp_t answer = '0);
        dir_row_t r;
        r.kind = ROW_REQUEST;
        r.func = fn;
        r.element = el;
        r.cap = '0;
        r.typed = typed;
        r.answer = answer;
        return r;
    endfunction

    function automatic dir_row_t cap_row(logic [CAP_W-1:0] value);
        dir_row_t r;
        r = req_row(FN_INSERT, '0);
        r.kind = ROW_CAP;
        r.cap = value;
        return r;
    endfunction

    // Pick an element for the current capacity: mostly inside the range,
    // some on the boundary, some anywhere in the field.
    function automatic logic [ELEM_W-1:0] pick_element();
        int lim;
        int roll;
        lim = (shadow_cap > ELEM_SPAN) ? ELEM_SPAN : int'(shadow_cap);
        roll = $urandom_range(99);
        if (lim == 0 || roll < 15)
            return ELEM_W'($urandom_range(ELEM_SPAN - 1));
        if (roll < 22)
            return ELEM_W'((lim - 1 + $urandom_range(1)) % ELEM_SPAN);
        return ELEM_W'($urandom_range(lim - 1));
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return FN_INSERT;
        if (roll < 50) return FN_ERASE;
        if (roll < 65) return FN_FIND;
        if (roll < 80) return FN_FIRST;
        if (roll < 88) return FN_COUNT;
        if (roll < 95) return FN_EMPTY;
        return FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));  // unused codes
    endfunction

    // Capacity settings of the random phases, extremes included.
    logic [CAP_W-1:0] phase_caps[$] = '{11'd1024, 11'd64, 11'd1, 11'd2047, 11'd65,
                                        11'd700, 11'd0, 11'd1023, 11'd1024};

    initial begin
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        stall_pct     = 0;
        burst_left    = 0;
        max_gap       = 0;
        shadow_set    = '0;
        shadow_cap    = CAP_RESET;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        req.valid     = 1'b0;
        req.func      = '0;
        req.element   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty set after reset, both ends of the range,
        // unused codes, zero capacity, capacity above the limit, hidden members.
        dir_rows.push_back(req_row(FN_COUNT, 10'd0, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_EMPTY, 10'd0, 1'b1, answer_of(0, 0, 1)));
        dir_rows.push_back(req_row(FN_FIND, 10'd1023, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_FIRST, 10'd0, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_INSERT, 10'd0));
        dir_rows.push_back(req_row(FN_INSERT, 10'd1023));
        dir_rows.push_back(req_row(FN_FIND, 10'd1023));
        dir_rows.push_back(req_row(FN_FIRST, 10'd1));
        dir_rows.push_back(req_row(FN_FIRST, 10'd1023));
        dir_rows.push_back(req_row(FN_COUNT, 10'd0));
        dir_rows.push_back(req_row(FN_EMPTY, 10'd0));
        dir_rows.push_back(req_row(FN_SPARE_LO, 10'd555, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_SPARE_HI, 10'd1023, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_ERASE, 10'd0));
        dir_rows.push_back(cap_row(11'd0));
        dir_rows.push_back(req_row(FN_INSERT, 10'd5, 1'b1, answer_of(1, 0, 0)));
        dir_rows.push_back(req_row(FN_FIND, 10'd0, 1'b1, answer_of(1, 0, 0)));
        dir_rows.push_back(req_row(FN_FIRST, 10'd0, 1'b1, answer_of(1, 0, 0)));
        dir_rows.push_back(req_row(FN_COUNT, 10'd0, 1'b1, answer_of(0, 0, 0)));
        dir_rows.push_back(req_row(FN_EMPTY, 10'd0, 1'b1, answer_of(0, 0, 1)));
        dir_rows.push_back(cap_row(11'd2047));
        dir_rows.push_back(req_row(FN_COUNT, 10'd0));
        dir_rows.push_back(cap_row(11'd1023));
        // Only element 1023 is stored, so it is now hidden.
        dir_rows.push_back(req_row(FN_FIND, 10'd1023, 1'b1, answer_of(1, 0, 0)));
        dir_rows.push_back(req_row(FN_EMPTY, 10'd0, 1'b1, answer_of(0, 0, 1)));
        dir_rows.push_back(req_row(FN_ERASE, 10'd1023, 1'b1, answer_of(1, 0, 0)));
        dir_rows.push_back(cap_row(11'd1024));
        dir_rows.push_back(req_row(FN_FIRST, 10'd0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CAP)
                write_capacity(dir_rows[i].cap);
            else
                send_request(dir_rows[i].func, dir_rows[i].element,
                             dir_rows[i].typed, dir_rows[i].answer);
        end

        // Random phases: new capacity, new idling profile, inserts the most common
        // operation so the set fills up and the scans have members to find. Every
        // third phase, starting with phase 0, runs back to back with no stalls.
        foreach (phase_caps[p])
        begin
            write_capacity((p == 7) ? CAP_W'($urandom_range(2047)) : phase_caps[p]);
            stall_pct = (p % 3 == 0) ? 0 : $urandom_range(70);
            max_gap   = (p % 3 == 0) ? 0 : $urandom_range(6);
            repeat (225)
                send_request(pick_func(), pick_element(), 1'b0, '0);
        end

        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses over %0d capacity settings",
                 sent_count, checked_count, phase_caps.size() + 4);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial begin
        #20_000_000;
        $display("Timeout with %0d responses outstanding", pending_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- bitmap_set_engine.f -----
hw/rtl/bse_pkg.sv
hw/rtl/bse_if.sv
hw/rtl/bse_front.sv
hw/rtl/bse_queue.sv
hw/rtl/bse_back.sv
hw/rtl/bitmap_set_engine.sv
hw/rtl/bse_checker.sv
verif/bitmap_set_engine_test.sv
